@@ rtl/core/qvr_pkg.sv @@
// qvr_pkg: widths, types and register indexes shared by the quaternion rotate core.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package qvr_pkg;

  localparam int VECTOR_BITS = 16;            // width of one vector component, Q8.8
  localparam int QUAT_BITS   = 16;            // quaternion component, Q1.14
  localparam int FRAC_SHIFT  = 28;            // fraction bits dropped at the end

  // first product q*v, then t = sum of three products
  localparam int PROD1_W = QUAT_BITS + VECTOR_BITS;
  localparam int T_W     = VECTOR_BITS + QUAT_BITS + 1;
  // second product t*q, then sum of four plus rounding bias
  localparam int PROD2_W = T_W + QUAT_BITS;
  localparam int ACC_W   = PROD2_W + 3;
  localparam int SH_W    = ACC_W - FRAC_SHIFT;

  localparam int VEC_DATA_W = ((3 * VECTOR_BITS + 7) / 8) * 8;

  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W - FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT - 1){1'b0}}};

  localparam logic signed [QUAT_BITS-1:0] QUAT_ONE = QUAT_BITS'(16384);

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_Z = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_W = CFG_IDX_W'(3);

  typedef struct packed {
    logic signed [QUAT_BITS-1:0] w;
    logic signed [QUAT_BITS-1:0] z;
    logic signed [QUAT_BITS-1:0] y;
    logic signed [QUAT_BITS-1:0] x;
  } quat_t;

  // x in the low bits so it maps straight onto tdata
  typedef struct packed {
    logic signed [VECTOR_BITS-1:0] z;
    logic signed [VECTOR_BITS-1:0] y;
    logic signed [VECTOR_BITS-1:0] x;
  } vec_t;

  // intermediate quaternion q * (v, 0)
  typedef struct packed {
    logic signed [T_W-1:0] w;
    logic signed [T_W-1:0] x;
    logic signed [T_W-1:0] y;
    logic signed [T_W-1:0] z;
  } tquat_t;

  // unrounded sums, 36 fraction bits
  typedef struct packed {
    logic signed [ACC_W-1:0] z;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] x;
  } acc_t;

endpackage

@@ rtl/core/quaternion_vector_rotate.sv @@
// Rotates each input vector v by the programmed quaternion q as q * v * conj(q). The core
// takes one vector word per clock while the output does not stall it, and passes it through
// its register stages: two for q * (v, 0) (products, sums), two for the product with
// conj(q) (products, sums plus rounding bias) and one for rounding to Q8.8 and clipping.
// Each stage holds its own valid bit, so a stalled output only backs up as far as the first
// empty stage. The quaternion (Q1.14, reset to identity) is used unnormalized and should
// only be rewritten while no word is in flight.
// Depends on qvr_pkg, qvr_cfg_regs, qvr_tprod, qvr_cprod and qvr_round_sat.
`timescale 1ns / 1ps

module quaternion_vector_rotate import qvr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VEC_DATA_W-1:0] in_tdata,   // vec_x, vec_y, vec_z from bit 0 up
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [VEC_DATA_W-1:0] out_tdata,  // rot_x, rot_y, rot_z from bit 0 up
  output logic                  out_tuser,  // saturated
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [QUAT_BITS-1:0]  cfg_data
);

  quat_t  quat;
  vec_t   vec;
  vec_t   rot;
  tquat_t t;
  acc_t   acc;
  logic   t_valid, t_ready;
  logic   acc_valid, acc_ready;

  assign vec = in_tdata[3*VECTOR_BITS-1:0];

  qvr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .quat      (quat)
  );

  qvr_tprod u_tprod (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .vec      (vec),
    .quat     (quat),
    .dn_valid (t_valid),
    .dn_ready (t_ready),
    .t        (t)
  );

  qvr_cprod u_cprod (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (t_valid),
    .up_ready (t_ready),
    .t        (t),
    .quat     (quat),
    .dn_valid (acc_valid),
    .dn_ready (acc_ready),
    .acc      (acc)
  );

  qvr_round_sat u_rsat (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (acc_valid),
    .up_ready (acc_ready),
    .acc      (acc),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .rot      (rot),
    .sat      (out_tuser)
  );

  always_comb begin
    out_tdata                     = '0;
    out_tdata[3*VECTOR_BITS-1:0]  = rot;
  end

endmodule

@@ rtl/core/qvr_cfg_regs.sv @@
// qvr_cfg_regs: quaternion register file written through the config channel.
// Depends on qvr_pkg.
`timescale 1ns / 1ps

module qvr_cfg_regs import qvr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [QUAT_BITS-1:0] cfg_data,
  output quat_t                quat
);

  quat_t quat_r, quat_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    quat_nxt = quat_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_QUAT_X: quat_nxt.x = cfg_data;
        CFG_QUAT_Y: quat_nxt.y = cfg_data;
        CFG_QUAT_Z: quat_nxt.z = cfg_data;
        CFG_QUAT_W: quat_nxt.w = cfg_data;
        default:    quat_nxt = quat_r;   // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r.x <= '0;
      quat_r.y <= '0;
      quat_r.z <= '0;
      quat_r.w <= QUAT_ONE;
    end else begin
      quat_r <= quat_nxt;
    end
  end

  assign quat = quat_r;

endmodule

@@ rtl/core/qvr_tprod.sv @@
// qvr_tprod: first half of the rotation, t = q * (v, 0), in two register stages
// (twelve products, then four three-term sums). Depends on qvr_pkg.
`timescale 1ns / 1ps

module qvr_tprod import qvr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  vec_t   vec,
  input  quat_t  quat,
  output logic   dn_valid,
  input  logic   dn_ready,
  output tquat_t t
);

  logic signed [PROD1_W-1:0] prod_r   [12];
  logic signed [PROD1_W-1:0] prod_nxt [12];
  logic                      prod_vld_r;
  logic                      prod_rdy;
  tquat_t                    t_r, t_nxt;
  logic                      t_vld_r;
  logic                      t_rdy;

  assign t_rdy    = !t_vld_r || dn_ready;
  assign prod_rdy = !prod_vld_r || t_rdy;
  assign up_ready = prod_rdy;

  always_comb begin
    prod_nxt[0]  = quat.x * vec.x;
    prod_nxt[1]  = quat.y * vec.y;
    prod_nxt[2]  = quat.z * vec.z;
    prod_nxt[3]  = quat.w * vec.x;
    prod_nxt[4]  = quat.y * vec.z;
    prod_nxt[5]  = quat.z * vec.y;
    prod_nxt[6]  = quat.w * vec.y;
    prod_nxt[7]  = quat.x * vec.z;
    prod_nxt[8]  = quat.z * vec.x;
    prod_nxt[9]  = quat.w * vec.z;
    prod_nxt[10] = quat.x * vec.y;
    prod_nxt[11] = quat.y * vec.x;
  end

  always_comb begin
    t_nxt.w = -T_W'(prod_r[0]) - T_W'(prod_r[1]) - T_W'(prod_r[2]);
    t_nxt.x =  T_W'(prod_r[3]) + T_W'(prod_r[4]) - T_W'(prod_r[5]);
    t_nxt.y =  T_W'(prod_r[6]) - T_W'(prod_r[7]) + T_W'(prod_r[8]);
    t_nxt.z =  T_W'(prod_r[9]) + T_W'(prod_r[10]) - T_W'(prod_r[11]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      t_vld_r    <= 1'b0;
    end else begin
      if (prod_rdy) prod_vld_r <= up_valid;
      if (t_rdy)    t_vld_r    <= prod_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_rdy && up_valid) begin
      for (int i = 0; i < 12; i++) prod_r[i] <= prod_nxt[i];
    end
    if (t_rdy && prod_vld_r) t_r <= t_nxt;
  end

  assign dn_valid = t_vld_r;
  assign t        = t_r;

endmodule

@@ rtl/core/qvr_cprod.sv @@
// qvr_cprod: second half, r = t * conj(q), as twelve products and three
// four-term sums with the rounding bias folded in. Depends on qvr_pkg.
`timescale 1ns / 1ps

module qvr_cprod import qvr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  tquat_t t,
  input  quat_t  quat,
  output logic   dn_valid,
  input  logic   dn_ready,
  output acc_t   acc
);

  logic signed [PROD2_W-1:0] prod_r   [12];
  logic signed [PROD2_W-1:0] prod_nxt [12];
  logic                      prod_vld_r;
  logic                      prod_rdy;
  acc_t                      acc_r, acc_nxt;
  logic                      acc_vld_r;
  logic                      acc_rdy;

  assign acc_rdy  = !acc_vld_r || dn_ready;
  assign prod_rdy = !prod_vld_r || acc_rdy;
  assign up_ready = prod_rdy;

  // signs of conj(q) are applied in the sums so that -(-1.0) never overflows
  always_comb begin
    prod_nxt[0]  = t.w * quat.x;
    prod_nxt[1]  = t.x * quat.w;
    prod_nxt[2]  = t.y * quat.z;
    prod_nxt[3]  = t.z * quat.y;
    prod_nxt[4]  = t.w * quat.y;
    prod_nxt[5]  = t.x * quat.z;
    prod_nxt[6]  = t.y * quat.w;
    prod_nxt[7]  = t.z * quat.x;
    prod_nxt[8]  = t.w * quat.z;
    prod_nxt[9]  = t.x * quat.y;
    prod_nxt[10] = t.y * quat.x;
    prod_nxt[11] = t.z * quat.w;
  end

  always_comb begin
    acc_nxt.x = -ACC_W'(prod_r[0]) + ACC_W'(prod_r[1]) - ACC_W'(prod_r[2])
                + ACC_W'(prod_r[3]) + ROUND_HALF;
    acc_nxt.y = -ACC_W'(prod_r[4]) + ACC_W'(prod_r[5]) + ACC_W'(prod_r[6])
                - ACC_W'(prod_r[7]) + ROUND_HALF;
    acc_nxt.z = -ACC_W'(prod_r[8]) - ACC_W'(prod_r[9]) + ACC_W'(prod_r[10])
                + ACC_W'(prod_r[11]) + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      acc_vld_r  <= 1'b0;
    end else begin
      if (prod_rdy) prod_vld_r <= up_valid;
      if (acc_rdy)  acc_vld_r  <= prod_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_rdy && up_valid) begin
      for (int i = 0; i < 12; i++) prod_r[i] <= prod_nxt[i];
    end
    if (acc_rdy && prod_vld_r) acc_r <= acc_nxt;
  end

  assign dn_valid = acc_vld_r;
  assign acc      = acc_r;

endmodule

@@ rtl/core/qvr_round_sat.sv @@
// qvr_round_sat: drops the fraction bits (bias already added), clips each
// component to VECTOR_BITS and holds the output word. Depends on qvr_pkg.
`timescale 1ns / 1ps

module qvr_round_sat import qvr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  acc_t acc,
  output logic dn_valid,
  input  logic dn_ready,
  output vec_t rot,
  output logic sat
);

  logic signed [SH_W-1:0] sh   [3];
  logic                   ovf  [3];
  logic [VECTOR_BITS-1:0] clip [3];
  vec_t                   rot_r, rot_nxt;
  logic                   sat_r, sat_nxt;
  logic                   out_vld_r;
  logic                   out_rdy;

  assign out_rdy  = !out_vld_r || dn_ready;
  assign up_ready = out_rdy;

  always_comb begin
    sh[0] = SH_W'(acc.x >>> FRAC_SHIFT);
    sh[1] = SH_W'(acc.y >>> FRAC_SHIFT);
    sh[2] = SH_W'(acc.z >>> FRAC_SHIFT);
    for (int i = 0; i < 3; i++) begin
      // fits when the sign position and all bits above it agree
      ovf[i]  = !((&sh[i][SH_W-1:VECTOR_BITS-1]) || !(|sh[i][SH_W-1:VECTOR_BITS-1]));
      clip[i] = ovf[i] ? {sh[i][SH_W-1], {(VECTOR_BITS-1){~sh[i][SH_W-1]}}}
                       : sh[i][VECTOR_BITS-1:0];
    end
    rot_nxt.x = clip[0];
    rot_nxt.y = clip[1];
    rot_nxt.z = clip[2];
    sat_nxt   = ovf[0] || ovf[1] || ovf[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_rdy) begin
      out_vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && up_valid) begin
      rot_r <= rot_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign dn_valid = out_vld_r;
  assign rot      = rot_r;
  assign sat      = sat_r;

endmodule
